// ----- rtl/core/wfl_pkg.sv -----
// ----------------------------------------------------------------------------
// wfl_pkg: shared types and constants for the wave flux limiter
// Limiter codes, register indexes, fixed-point constants, controller state and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wfl_pkg;

    localparam int WAVE_W  = 32;   // Q8.24 wave component
    localparam int PHI_W   = 32;   // Q16.16 limiter value
    localparam int ACC_W   = 64;   // Q16.48 dot/norm sums
    localparam int MODE_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // iterative divider: dividend bits, quotient bits (quotient known < 2^31)
    localparam int DIV_N_W = 80;
    localparam int DIV_Q_W = 31;
    localparam int DIV_CNT_W = 5;

    localparam logic signed [PHI_W-1:0] PHI_ONE = 32'sh0001_0000;
    localparam logic signed [PHI_W-1:0] R_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [PHI_W-1:0] R_MIN   = 32'sh8000_0000;

    // limiter codes
    localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MINMOD   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUPERBEE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_VANLEER  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MC       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BEAMWARM = 3'd5;
    localparam logic [MODE_W-1:0] MODE_ZERO     = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_OVERRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_EN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_AT_BND  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_RATIO,
        ST_RDIV,
        ST_PHI,
        ST_VDIV,
        ST_SMUL,
        ST_SLOAD,
        ST_SWAIT,
        ST_COMMIT
    } wfl_state_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic acc;
        logic ratio_start;
        logic ratio_take;
        logic phi_eval;
        logic vl_take;
        logic scale_mul;
        logic out_load;
        logic out_next;
        logic commit;
    } wfl_cmd_t;

    typedef struct packed {
        logic edge_end;
        logic emit_on;
        logic need_rdiv;
        logic need_vdiv;
        logic div_done;
        logic out_taken;
        logic last_k;
    } wfl_status_t;

endpackage

// ----- rtl/core/wfl_div.sv -----
// ----------------------------------------------------------------------------
// wfl_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. Caller guarantees the
// quotient is below 2^31, so only the low 31 bits are developed.
// ----------------------------------------------------------------------------
module wfl_div
    import wfl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] num,
    input  logic [ACC_W-1:0]   den,
    output logic               done,
    output logic [DIV_Q_W-1:0] quo
);

    logic [ACC_W:0]         rem_reg,  rem_next;
    logic [DIV_Q_W-1:0]     low_reg,  low_next;
    logic [DIV_Q_W-1:0]     quo_reg,  quo_next;
    logic [ACC_W-1:0]       den_reg,  den_next;
    logic [DIV_CNT_W-1:0]   cnt_reg,  cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [ACC_W:0]         trial;
    logic                   fits;

    assign trial = {rem_reg[ACC_W-1:0], low_reg[DIV_Q_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // top bits of the dividend are already below the divisor
            rem_next  = {{(ACC_W+1-(DIV_N_W-DIV_Q_W)){1'b0}}, num[DIV_N_W-1:DIV_Q_W]};
            low_next  = num[DIV_Q_W-1:0];
            den_next  = den;
            cnt_next  = DIV_CNT_W'(DIV_Q_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - {1'b0, den_reg}) : trial;
            low_next = {low_reg[DIV_Q_W-2:0], 1'b0};
            quo_next = {quo_reg[DIV_Q_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- rtl/core/wfl_dp.sv -----
// ----------------------------------------------------------------------------
// wfl_dp: limiter datapath
// Edge wave buffers, dot/norm accumulators, ratio and limiter evaluation,
// scaling multiplier and the output register.
// ----------------------------------------------------------------------------
module wfl_dp
    import wfl_pkg::*;
#(
    parameter int COMPONENTS = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic signed [WAVE_W-1:0] wave_component,
    input  logic                     last_component,
    input  logic                     end_of_slice,
    input  logic                     speed_positive,
    input  logic [MODE_W-1:0]        mode_override,
    input  logic                     left_outside,
    input  logic                     right_outside,
    input  wfl_cmd_t                 cmd,
    output wfl_status_t              status,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic signed [WAVE_W-1:0] limited_component,
    output logic signed [PHI_W-1:0]  limiter_value,
    output logic                     last_of_edge
);

    localparam int CI_W = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
    localparam logic [CI_W:0] LAST_IDX = (CI_W+1)'(COMPONENTS - 1);

    // configuration
    logic [MODE_W-1:0] def_mode_reg;
    logic              use_ovr_reg, bnd_en_reg, zab_reg;

    // captured input item
    logic signed [WAVE_W-1:0] w_reg;
    logic                     last_reg, eos_reg, spd_reg, lo_reg, ro_reg;
    logic [MODE_W-1:0]        ovr_reg;

    logic signed [WAVE_W-1:0] prev_wave_reg [COMPONENTS];
    logic signed [WAVE_W-1:0] cur_wave_reg  [COMPONENTS];

    logic signed [ACC_W-1:0] prod_dot_reg, prod_norm_reg;
    logic signed [ACC_W-1:0] dot_left_reg, dot_acc_reg, norm_prev_reg, norm_acc_reg;
    logic [3:0]              pflags_reg;
    logic [CI_W-1:0]         ci_reg, k_reg;
    logic [1:0]              edges_reg;

    logic signed [PHI_W-1:0] r_reg, phi_reg;
    logic                    zero_norm_reg, neg_reg;
    logic signed [ACC_W-1:0] scale_prod_reg;

    logic                     out_valid_reg;
    logic signed [WAVE_W-1:0] out_comp_reg;
    logic signed [PHI_W-1:0]  out_phi_reg;
    logic                     out_last_reg;

    // --- shared read port of the previous-edge buffer
    logic [CI_W-1:0]          rd_idx;
    logic signed [WAVE_W-1:0] prev_rd;

    assign rd_idx  = cmd.scale_mul ? k_reg : ci_reg;
    assign prev_rd = prev_wave_reg[rd_idx];

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            sat_add = s[ACC_W-1:0];
    endfunction

    // --- edge end and mode resolve
    logic              edge_end;
    logic [MODE_W-1:0] mode_res;

    assign edge_end = last_reg || ({1'b0, ci_reg} == LAST_IDX);

    always_comb
    begin
        mode_res = use_ovr_reg ? ovr_reg : def_mode_reg;
        if (bnd_en_reg && zab_reg && (lo_reg != ro_reg))
            mode_res = MODE_ZERO;
    end

    // --- ratio setup
    logic signed [ACC_W-1:0] ratio_num;
    logic [ACC_W-1:0]        ratio_mag;
    logic                    ratio_pos_den, ratio_sat;

    assign ratio_num     = pflags_reg[3] ? dot_left_reg : dot_acc_reg;
    assign ratio_mag     = ratio_num[ACC_W-1] ? (ACC_W'(0) - ratio_num) : ratio_num;
    assign ratio_pos_den = norm_prev_reg > 0;
    assign ratio_sat     = (ratio_mag >> 15) >= norm_prev_reg;

    // --- limiter function on r_reg
    logic signed [PHI_W+1:0] rx, r2x, one_x, two_x, sb_a, sb_b, mc_x, mc_c, mc_m, lim_x;
    logic [MODE_W-1:0]       mode_cur;

    assign mode_cur = pflags_reg[2:0];

    always_comb
    begin
        rx    = {{2{r_reg[PHI_W-1]}}, r_reg};
        r2x   = rx <<< 1;
        one_x = {2'b00, PHI_ONE};
        two_x = one_x <<< 1;
        sb_a  = (r2x < one_x) ? r2x : one_x;
        sb_b  = (rx < two_x) ? rx : two_x;
        mc_x  = one_x + rx;
        mc_c  = (mc_x + {{(PHI_W+1){1'b0}}, mc_x[PHI_W+1]}) >>> 1;
        mc_m  = (two_x < r2x) ? two_x : r2x;
        mc_m  = (mc_c < mc_m) ? mc_c : mc_m;
        unique case (mode_cur)
            MODE_MINMOD:   lim_x = (rx < one_x) ? rx : one_x;
            MODE_SUPERBEE: lim_x = (sb_a > sb_b) ? sb_a : sb_b;
            MODE_VANLEER:  lim_x = '0;
            MODE_MC:       lim_x = mc_m;
            MODE_BEAMWARM: lim_x = rx;
            MODE_ZERO:     lim_x = '0;
            default:       lim_x = one_x;
        endcase
        if ((mode_cur != MODE_BEAMWARM) && lim_x[PHI_W+1])
            lim_x = '0;
    end

    logic need_vdiv;
    assign need_vdiv = !zero_norm_reg && (mode_cur == MODE_VANLEER) && (r_reg > 0);

    // --- divider, shared between ratio and van Leer
    logic                div_start, div_done;
    logic [DIV_N_W-1:0]  div_num;
    logic [ACC_W-1:0]    div_den;
    logic [DIV_Q_W-1:0]  div_quo;

    assign div_start = (cmd.ratio_start && ratio_pos_den && !ratio_sat)
                     || (cmd.phi_eval && need_vdiv);

    always_comb
    begin
        if (cmd.ratio_start)
        begin
            div_num = {ratio_mag, 16'b0};
            div_den = norm_prev_reg;
        end
        else
        begin
            // 2 r / (1 + r) in Q16.16
            div_num = {32'b0, r_reg[PHI_W-2:0], 17'b0};
            div_den = {{(ACC_W-PHI_W-1){1'b0}}, {1'b0, PHI_ONE} + {1'b0, r_reg}};
        end
    end

    wfl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // --- scaling result: floor to Q8.24 and saturate
    logic signed [ACC_W-17:0] scaled;
    logic signed [WAVE_W-1:0] scaled_sat;

    assign scaled = scale_prod_reg[ACC_W-1:16];

    always_comb
    begin
        if (scaled > $signed({{(ACC_W-16-WAVE_W){1'b0}}, 1'b0, {(WAVE_W-1){1'b1}}}))
            scaled_sat = {1'b0, {(WAVE_W-1){1'b1}}};
        else if (scaled < $signed({{(ACC_W-16-WAVE_W){1'b1}}, 1'b1, {(WAVE_W-1){1'b0}}}))
            scaled_sat = {1'b1, {(WAVE_W-1){1'b0}}};
        else
            scaled_sat = scaled[WAVE_W-1:0];
    end

    logic out_taken;
    assign out_taken = out_valid_reg && !out_stall;

    // --- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_mode_reg  <= '0;
            use_ovr_reg   <= 1'b0;
            bnd_en_reg    <= 1'b0;
            zab_reg       <= 1'b0;
            dot_left_reg  <= '0;
            dot_acc_reg   <= '0;
            norm_prev_reg <= '0;
            norm_acc_reg  <= '0;
            pflags_reg    <= '0;
            ci_reg        <= '0;
            k_reg         <= '0;
            edges_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_DEFAULT_MODE: def_mode_reg <= cfg_data;
                    CFG_USE_OVERRIDE: use_ovr_reg  <= cfg_data[0];
                    CFG_BOUNDARY_EN:  bnd_en_reg   <= cfg_data[0];
                    CFG_ZERO_AT_BND:  zab_reg      <= cfg_data[0];
                endcase
            end
            if (cmd.acc)
            begin
                dot_acc_reg  <= sat_add(dot_acc_reg, prod_dot_reg);
                norm_acc_reg <= sat_add(norm_acc_reg, prod_norm_reg);
                if (!edge_end)
                    ci_reg <= ci_reg + 1'b1;
            end
            if (cmd.ratio_start)
                k_reg <= '0;
            if (cmd.out_next)
                k_reg <= k_reg + 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_taken)
                out_valid_reg <= 1'b0;
            if (cmd.commit)
            begin
                pflags_reg    <= {spd_reg, mode_res};
                dot_left_reg  <= dot_acc_reg;
                norm_prev_reg <= norm_acc_reg;
                dot_acc_reg   <= '0;
                norm_acc_reg  <= '0;
                ci_reg        <= '0;
                if (eos_reg)
                    edges_reg <= '0;
                else if (edges_reg < 2'd2)
                    edges_reg <= edges_reg + 1'b1;
            end
        end
    end

    // --- payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            w_reg    <= wave_component;
            last_reg <= last_component;
            eos_reg  <= end_of_slice;
            spd_reg  <= speed_positive;
            ovr_reg  <= mode_override;
            lo_reg   <= left_outside;
            ro_reg   <= right_outside;
        end
        if (cmd.mul)
        begin
            prod_dot_reg  <= w_reg * prev_rd;
            prod_norm_reg <= w_reg * w_reg;
        end
        if (cmd.acc)
        begin
            for (int i = 0; i < COMPONENTS; i++)
            begin
                if (i == int'(ci_reg))
                    cur_wave_reg[i] <= w_reg;
                else if (edge_end && (i > int'(ci_reg)))
                    cur_wave_reg[i] <= '0;
            end
        end
        if (cmd.ratio_start)
        begin
            zero_norm_reg <= !ratio_pos_den;
            neg_reg       <= ratio_num[ACC_W-1];
            if (ratio_sat)
                r_reg <= ratio_num[ACC_W-1] ? R_MIN : R_MAX;
        end
        if (cmd.ratio_take)
            r_reg <= neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        if (cmd.phi_eval)
            phi_reg <= zero_norm_reg ? PHI_ONE : lim_x[PHI_W-1:0];
        if (cmd.vl_take)
            phi_reg <= $signed({1'b0, div_quo});
        if (cmd.scale_mul)
            scale_prod_reg <= prev_rd * phi_reg;
        if (cmd.out_load)
        begin
            out_comp_reg <= scaled_sat;
            out_phi_reg  <= phi_reg;
            out_last_reg <= ({1'b0, k_reg} == LAST_IDX);
        end
        if (cmd.commit)
        begin
            for (int i = 0; i < COMPONENTS; i++)
                prev_wave_reg[i] <= cur_wave_reg[i];
        end
    end

    assign status.edge_end  = edge_end;
    assign status.emit_on   = edges_reg == 2'd2;
    assign status.need_rdiv = ratio_pos_den && !ratio_sat;
    assign status.need_vdiv = need_vdiv;
    assign status.div_done  = div_done;
    assign status.out_taken = out_taken;
    assign status.last_k    = ({1'b0, k_reg} == LAST_IDX);

    assign out_valid         = out_valid_reg;
    assign limited_component = out_comp_reg;
    assign limiter_value     = out_phi_reg;
    assign last_of_edge      = out_last_reg;

endmodule

// ----- rtl/core/wfl_ctrl.sv -----
// ----------------------------------------------------------------------------
// wfl_ctrl: limiter sequencer
// Steps one component through multiply/accumulate and, at an edge end, the
// ratio, limiter, per-component scaling (interior edge held) and buffer commit.
// ----------------------------------------------------------------------------
module wfl_ctrl
    import wfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  wfl_status_t status,
    output wfl_cmd_t    cmd
);

    wfl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:
            begin
                if (!status.edge_end)
                    state_next = ST_IDLE;
                else if (status.emit_on)
                    state_next = ST_RATIO;
                else
                    state_next = ST_COMMIT;
            end
            ST_RATIO:  state_next = status.need_rdiv ? ST_RDIV : ST_PHI;
            ST_RDIV:   if (status.div_done) state_next = ST_PHI;
            ST_PHI:    state_next = status.need_vdiv ? ST_VDIV : ST_SMUL;
            ST_VDIV:   if (status.div_done) state_next = ST_SMUL;
            ST_SMUL:   state_next = ST_SLOAD;
            ST_SLOAD:  state_next = ST_SWAIT;
            ST_SWAIT:
            begin
                if (status.out_taken)
                    state_next = status.last_k ? ST_COMMIT : ST_SMUL;
            end
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_MUL:    cmd.mul         = 1'b1;
            ST_ACC:    cmd.acc         = 1'b1;
            ST_RATIO:  cmd.ratio_start = 1'b1;
            ST_RDIV:   cmd.ratio_take  = status.div_done;
            ST_PHI:    cmd.phi_eval    = 1'b1;
            ST_VDIV:   cmd.vl_take     = status.div_done;
            ST_SMUL:   cmd.scale_mul   = 1'b1;
            ST_SLOAD:  cmd.out_load    = 1'b1;
            ST_SWAIT:  cmd.out_next    = status.out_taken && !status.last_k;
            ST_COMMIT: cmd.commit      = 1'b1;
            default:   cmd             = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/core/wave_flux_limiter_unit.sv -----
// ----------------------------------------------------------------------------
// wave_flux_limiter_unit: high-resolution wave limiter, top level
// Takes one wave family edge by edge, one component per transfer; when an edge
// closes with an interior edge held, that held edge is limited and sent out.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+-------------------------
//  input   | in_valid, in_stall, wave_component, flags | in_valid && !in_stall
//  output  | out_valid, out_stall, limited_component,  | out_valid && !out_stall
//          | limiter_value, last_of_edge               |
//  config  | cfg_write, cfg_index, cfg_data            | cfg_write
//
//  Steps: a component that does not close an edge goes through capture,
//  multiply and accumulate. Closing an edge with an interior edge held adds the
//  ratio (at most one divide in the 31-step divider), the limiter (a second
//  divide for van Leer), per emitted component a multiply, load and wait that
//  output stalls extend, and a commit. Reset clears accumulators, flags,
//  counters and config; wave buffers are not cleared. in_stall stays high from
//  capture until the component, or at an edge end the whole edge, is done.
//
// ----------------------------------------------------------------------------
module wave_flux_limiter_unit
    import wfl_pkg::*;
#(
    parameter int COMPONENTS = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration write port
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [WAVE_W-1:0] wave_component,
    input  logic                     last_component,
    input  logic                     end_of_slice,
    input  logic                     speed_positive,
    input  logic [MODE_W-1:0]        mode_override,
    input  logic                     left_outside,
    input  logic                     right_outside,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WAVE_W-1:0] limited_component,
    output logic signed [PHI_W-1:0]  limiter_value,
    output logic                     last_of_edge
);

    wfl_cmd_t    cmd;
    wfl_status_t status;

    // sequencer: owns in_stall, issues one command set per cycle
    wfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: buffers, accumulators, divider, scaling, output register
    wfl_dp #(
        .COMPONENTS (COMPONENTS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .wave_component    (wave_component),
        .last_component    (last_component),
        .end_of_slice      (end_of_slice),
        .speed_positive    (speed_positive),
        .mode_override     (mode_override),
        .left_outside      (left_outside),
        .right_outside     (right_outside),
        .cmd               (cmd),
        .status            (status),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .limited_component (limited_component),
        .limiter_value     (limiter_value),
        .last_of_edge      (last_of_edge)
    );

endmodule

// ----- rtl/core/wfl_checker.sv -----
// ----------------------------------------------------------------------------
// wfl_checker: port-level checks for the wave flux limiter
// Watches both channels of the top level over time.
// ----------------------------------------------------------------------------
module wfl_checker
    import wfl_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [WAVE_W-1:0] limited_component,
    input logic signed [PHI_W-1:0]  limiter_value,
    input logic                     last_of_edge
);

    // no input transfer while a result is pending
    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !out_valid)
        else $error("input transfer while a result is pending");

    // within an edge the block keeps emitting and takes no new input
    a_edge_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_edge) |=> in_stall)
        else $error("input opened before the edge was fully emitted");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(limited_component)
                                      && $stable(limiter_value)))
        else $error("stalled result changed");

endmodule

bind wave_flux_limiter_unit wfl_checker u_wfl_checker (.*);

// ----- sim/tb_wave_flux_limiter_unit.sv -----
// ----------------------------------------------------------------------------
// tb_wave_flux_limiter_unit: self-checking testbench for the wave limiter
// Drives edge waves one component per transfer, predicts every limited
// component with an in-bench model of the limiter and compares each output
// transfer against the oldest prediction, under random bursts and stalls.
// ----------------------------------------------------------------------------
module tb_wave_flux_limiter_unit;
    import wfl_pkg::*;

    localparam int NCOMP      = 4;
    localparam int DRAIN_WAIT = 200;     // covers ratio + van Leer divides
    localparam int CYCLE_CAP  = 600000;

    // code outside the limiter list, behaves as no limiter
    localparam logic [MODE_W-1:0] MODE_UNDEF = 3'd7;

    // limited component as it should leave the block
    typedef struct {
        logic signed [WAVE_W-1:0] comp;
        logic signed [PHI_W-1:0]  phi;
        logic                     last;
    } limited_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [WAVE_W-1:0] wave_component;
    logic                     last_component;
    logic                     end_of_slice;
    logic                     speed_positive;
    logic [MODE_W-1:0]        mode_override;
    logic                     left_outside;
    logic                     right_outside;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [WAVE_W-1:0] limited_component;
    logic signed [PHI_W-1:0]  limiter_value;
    logic                     last_of_edge;

    wave_flux_limiter_unit #(.COMPONENTS(NCOMP)) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .wave_component    (wave_component),
        .last_component    (last_component),
        .end_of_slice      (end_of_slice),
        .speed_positive    (speed_positive),
        .mode_override     (mode_override),
        .left_outside      (left_outside),
        .right_outside     (right_outside),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .limited_component (limited_component),
        .limiter_value     (limiter_value),
        .last_of_edge      (last_of_edge)
    );

    // expected limited components, oldest first
    limited_t limited_q[$];
    int       errors;
    int       cycles;
    int       items_sent;
    int       results_seen;
    int       burst_left;

    // shadow of the block's registers and state
    logic [MODE_W-1:0]        sh_default_mode;
    logic                     sh_use_override;
    logic                     sh_boundary_en;
    logic                     sh_zero_at_bnd;
    logic signed [WAVE_W-1:0] held_wave [NCOMP];
    logic signed [WAVE_W-1:0] open_wave [NCOMP];
    longint                   held_dot_left;
    longint                   open_dot;
    longint                   held_norm;
    longint                   open_norm;
    logic                     held_speed;
    logic [MODE_W-1:0]        held_mode;
    int                       comp_idx;
    int                       edge_count;

    // ------------------------------------------------------------------------
    // clock, cycle cap
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // fixed-point arithmetic of the limiter
    // ------------------------------------------------------------------------
    function automatic longint sum_sat(longint a, longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            s = b[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        return s;
    endfunction

    // num / den as Q16.16, truncated toward zero, saturated; den > 0
    function automatic longint ratio_q16(longint num, longint den);
        longint unsigned mag, d, ip, rem, frac;
        longint          q;
        mag  = num < 0 ? 64'd0 - 64'(num) : 64'(num);
        d    = 64'(den);
        ip   = mag / d;
        rem  = mag % d;
        frac = 0;
        if (ip >= 64'd32768)
            return num < 0 ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
        for (int k = 0; k < 16; k++)
        begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= d)
            begin
                rem  = rem - d;
                frac = frac | 64'd1;
            end
        end
        q = longint'((ip << 16) | frac);
        return num < 0 ? -q : q;
    endfunction

    function automatic longint lmin(longint a, longint b);
        return a < b ? a : b;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function automatic longint phi_of(logic [MODE_W-1:0] mode, longint r);
        longint one;
        one = longint'(PHI_ONE);
        case (mode)
            MODE_MINMOD:   return lmax(0, lmin(one, r));
            MODE_SUPERBEE: return lmax(0, lmax(lmin(one, 2 * r), lmin(2 * one, r)));
            MODE_VANLEER:  return r <= 0 ? 0 : (2 * r * one) / (one + r);
            MODE_MC:       return lmax(0, lmin((one + r) / 2, lmin(2 * one, 2 * r)));
            MODE_BEAMWARM: return r;
            MODE_ZERO:     return 0;
            default:       return one;   // none, and the unknown code
        endcase
    endfunction

    // wave * phi, floored to Q8.24, saturated to 32 bits
    function automatic longint scaled_of(longint w, longint phi);
        longint q;
        q = (w * phi) >>> 16;
        if (q > 64'sh7FFF_FFFF)
            q = 64'sh7FFF_FFFF;
        if (q < -64'sh8000_0000)
            q = -64'sh8000_0000;
        return q;
    endfunction

    // one accepted component through the limiter model
    task automatic predict_limited(logic signed [WAVE_W-1:0] w, logic last, logic eos,
                                   logic spd, logic [MODE_W-1:0] ovr, logic lo, logic ro);
        longint            wl, phi, num;
        logic [MODE_W-1:0] mode;
        limited_t          lim;
        int                ci;
        wl = longint'(w);
        ci = comp_idx >= NCOMP ? 0 : comp_idx;
        open_wave[ci] = w;
        open_dot  = sum_sat(open_dot, wl * longint'(held_wave[ci]));
        open_norm = sum_sat(open_norm, wl * wl);
        if (!(last || ci + 1 >= NCOMP))
        begin
            comp_idx = ci + 1;
            return;
        end
        for (int k = ci + 1; k < NCOMP; k++)
            open_wave[k] = '0;
        // edge closes: finish the held edge if it is interior
        if (edge_count >= 2)
        begin
            phi = longint'(PHI_ONE);
            if (held_norm > 0)
            begin
                num = held_speed ? held_dot_left : open_dot;
                phi = phi_of(held_mode, ratio_q16(num, held_norm));
            end
            for (int k = 0; k < NCOMP; k++)
            begin
                lim.comp = held_norm > 0 ? WAVE_W'(scaled_of(longint'(held_wave[k]), phi))
                                         : held_wave[k];
                lim.phi  = PHI_W'(phi);
                lim.last = (k + 1 == NCOMP);
                limited_q = {limited_q, lim};
            end
        end
        mode = sh_use_override ? ovr : sh_default_mode;
        if (sh_boundary_en && sh_zero_at_bnd && lo != ro)
            mode = MODE_ZERO;
        held_speed    = spd;
        held_mode     = mode;
        held_wave     = open_wave;
        held_dot_left = open_dot;
        held_norm     = open_norm;
        open_dot      = 0;
        open_norm     = 0;
        comp_idx      = 0;
        if (eos)
            edge_count = 0;
        else if (edge_count < 2)
            edge_count++;
    endtask

    // ------------------------------------------------------------------------
    // output side: stall pattern and result check
    // ------------------------------------------------------------------------
    int stall_kind;
    int stall_span;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_kind <= 0;
            stall_span <= 0;
        end
        else
        begin
            // pick a new pattern when the span runs out: none, light, heavy
            if (stall_span == 0)
            begin
                stall_kind <= $urandom_range(0, 2);
                stall_span <= $urandom_range(10, 80);
            end
            else
                stall_span <= stall_span - 1;
            case (stall_kind)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    always @(posedge clk)
    begin
        limited_t exp_lim;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (limited_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output transfer comp=%h phi=%h last=%b",
                         $time, limited_component, limiter_value, last_of_edge);
            end
            else
            begin
                exp_lim = limited_q.pop_front();
                if (limited_component !== exp_lim.comp)
                begin
                    errors++;
                    $display("%0t: limited_component expected %h actual %h",
                             $time, exp_lim.comp, limited_component);
                end
                if (limiter_value !== exp_lim.phi)
                begin
                    errors++;
                    $display("%0t: limiter_value expected %h actual %h",
                             $time, exp_lim.phi, limiter_value);
                end
                if (last_of_edge !== exp_lim.last)
                begin
                    errors++;
                    $display("%0t: last_of_edge expected %b actual %b",
                             $time, exp_lim.last, last_of_edge);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    // one component transfer; the sender runs in random bursts with gaps
    task automatic send_component(logic signed [WAVE_W-1:0] w, logic last, logic eos,
                                  logic spd, logic [MODE_W-1:0] ovr, logic lo, logic ro);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid       <= 1'b1;
        wave_component <= w;
        last_component <= last;
        end_of_slice   <= eos;
        speed_positive <= spd;
        mode_override  <= ovr;
        left_outside   <= lo;
        right_outside  <= ro;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        items_sent++;
        predict_limited(w, last, eos, spd, ovr, lo, ro);
    endtask

    // wave value: full range, extremes, or scaled so ratios land near 1
    function automatic logic signed [WAVE_W-1:0] pick_wave();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2:       return 32'(signed'($urandom_range(0, 4000)) - 2000) <<< 16;
            default: return 32'(signed'($urandom_range(0, 400)) - 200) <<< 20;
        endcase
    endfunction

    // one edge of n components, flags random unless given
    task automatic send_edge(int n, logic eos, logic [MODE_W-1:0] ovr, bit tag_last);
        logic spd, lo, ro;
        spd = 1'($urandom_range(0, 1));
        lo  = 1'($urandom_range(0, 1));
        ro  = 1'($urandom_range(0, 1));
        for (int k = 0; k < n; k++)
            send_component(pick_wave(), tag_last && (k == n - 1), eos, spd, ovr, lo, ro);
    endtask

    // idle the input and let the block drain before touching registers
    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (limited_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // one register write; the caller lowers cfg_write after the last one
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_DEFAULT_MODE: sh_default_mode = val;
            CFG_USE_OVERRIDE: sh_use_override = val[0];
            CFG_BOUNDARY_EN:  sh_boundary_en  = val[0];
            default:          sh_zero_at_bnd  = val[0];
        endcase
    endtask

    task automatic set_regs(logic [MODE_W-1:0] dm, logic ovr_en, logic bnd, logic zab);
        drain();
        write_reg(CFG_DEFAULT_MODE, dm);
        write_reg(CFG_USE_OVERRIDE, CFG_DATA_W'(ovr_en));
        write_reg(CFG_BOUNDARY_EN, CFG_DATA_W'(bnd));
        write_reg(CFG_ZERO_AT_BND, CFG_DATA_W'(zab));
        cfg_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // each limiter through a short slice of one-component edges
    task automatic test_each_mode();
        for (int m = MODE_NONE; m <= MODE_ZERO; m++)
        begin
            set_regs(MODE_W'(m), 1'b0, 1'b0, 1'b0);
            send_edge(1, 1'b0, MODE_NONE, 1'b1);
            send_edge(1, 1'b0, MODE_NONE, 1'b1);
            send_edge(1, 1'b1, MODE_NONE, 1'b1);
        end
    endtask

    // extremes, zero norm, long edge, short slice, unknown code, boundary
    task automatic test_special_cases();
        set_regs(MODE_SUPERBEE, 1'b1, 1'b1, 1'b1);
        // saturated sums and ratio: largest waves against a tiny one
        for (int k = 0; k < NCOMP; k++)
            send_component(32'sh7FFF_FFFF, k == NCOMP - 1, 1'b0, 1'b1, MODE_BEAMWARM,
                           1'b0, 1'b0);
        send_component(32'sh0000_0001, 1'b1, 1'b0, 1'b0, MODE_BEAMWARM, 1'b0, 1'b0);
        // zero-norm edge passes through
        send_component('0, 1'b1, 1'b0, 1'b1, MODE_MC, 1'b0, 1'b0);
        // long edge without a last marker, unknown code
        for (int k = 0; k < NCOMP; k++)
            send_component(32'sh8000_0000, 1'b0, 1'b0, 1'b0, MODE_UNDEF, 1'b0, 1'b0);
        // one cell outside forces the zero limiter
        send_component(32'sh0100_0000, 1'b1, 1'b0, 1'b1, MODE_NONE, 1'b1, 1'b0);
        send_component(32'shFF00_0000, 1'b1, 1'b1, 1'b0, MODE_NONE, 1'b1, 1'b1);
        // short slice: end of slice before any interior edge is held
        send_component(32'sh0200_0000, 1'b1, 1'b0, 1'b0, MODE_MINMOD, 1'b0, 1'b1);
        send_component(32'sh0300_0000, 1'b1, 1'b1, 1'b0, MODE_MINMOD, 1'b0, 1'b1);
    endtask

    // random slices of well-formed edges with occasional broken ones
    task automatic test_random_slices(int target);
        int start, n_edges;
        start = items_sent;
        while (items_sent - start < target)
        begin
            if ($urandom_range(0, 2) == 0)
                set_regs(MODE_W'($urandom_range(0, 6)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            n_edges = $urandom_range(1, 6);
            for (int e = 0; e < n_edges; e++)
            begin
                if ($urandom_range(0, 9) == 0)
                    // noise: unmarked, end of slice anywhere, any override
                    send_edge($urandom_range(1, NCOMP), 1'($urandom_range(0, 1)),
                              MODE_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
                else
                    send_edge($urandom_range(1, NCOMP), e == n_edges - 1,
                              MODE_W'($urandom_range(0, 7)), 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        errors = 0;  cycles = 0;  items_sent = 0;  results_seen = 0;  burst_left = 0;
        sh_default_mode = MODE_NONE;  sh_use_override = 0;
        sh_boundary_en  = 0;          sh_zero_at_bnd  = 0;
        for (int k = 0; k < NCOMP; k++)
        begin
            held_wave[k] = '0;
            open_wave[k] = '0;
        end
        held_dot_left = 0;  open_dot = 0;  held_norm = 0;  open_norm = 0;
        held_speed = 0;  held_mode = MODE_NONE;  comp_idx = 0;  edge_count = 0;

        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        wave_component = '0;
        last_component = 1'b0;
        end_of_slice   = 1'b0;
        speed_positive = 1'b0;
        mode_override  = '0;
        left_outside   = 1'b0;
        right_outside  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_each_mode();
        test_special_cases();
        test_random_slices(120);

        drain();
        $display("Covered %0d component transfers in, %0d limited components out,",
                 items_sent, results_seen);
        $display("all seven limiters, override, boundary zeroing and short slices.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/wfl_pkg.sv
rtl/core/wfl_div.sv
rtl/core/wfl_dp.sv
rtl/core/wfl_ctrl.sv
rtl/core/wave_flux_limiter_unit.sv
rtl/core/wfl_checker.sv
sim/tb_wave_flux_limiter_unit.sv
